[hw/rtl/ktfi_pkg.sv]
// ktfi_pkg: shared types, widths and outcome codes for the key table block.
// No dependencies; compile first.
package ktfi_pkg;

    // Word and row geometry
    localparam int WORD_W          = 64;
    localparam int WORDS_PER_ENTRY = 4;
    localparam int ROW_W           = WORD_W * WORDS_PER_ENTRY;
    localparam int EMPTY_W         = 32;
    localparam int SLOT_W          = 5;
    localparam int OUTCOME_W       = 2;

    // Default table depth
    localparam int DEF_ENTRIES = 32;

    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [ROW_W-1:0]     t_row;
    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [OUTCOME_W-1:0] t_outcome;

    // Result outcome codes
    localparam t_outcome OUTCOME_FOUND    = 2'd0;
    localparam t_outcome OUTCOME_INSERTED = 2'd1;
    localparam t_outcome OUTCOME_FULL     = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic start;   // capture key, rewind scan, clear flags
        logic scan;    // read one row and advance the address
        logic commit;  // write the key if inserting, load the result word
    } t_dp_cmd;

endpackage

[hw/rtl/ktfi_if.sv]
// Valid/ready channel interfaces for key words in and result words out.
// Depends on ktfi_pkg.
interface ktfi_key_if;
    import ktfi_pkg::*;

    logic  valid;
    logic  ready;
    t_word key_word0;
    t_word key_word1;
    t_word key_word2;
    t_word key_word3;

    modport source (output valid, output key_word0, output key_word1,
                    output key_word2, output key_word3, input ready);
    modport sink   (input valid, input key_word0, input key_word1,
                    input key_word2, input key_word3, output ready);
endinterface

interface ktfi_res_if;
    import ktfi_pkg::*;

    logic     valid;
    logic     ready;
    t_slot    slot_index;
    t_outcome outcome;

    modport source (output valid, output slot_index, output outcome, input ready);
    modport sink   (input valid, input slot_index, input outcome, output ready);
endinterface

[hw/rtl/key_table_find_or_insert.sv]
// Key table find-or-insert: a table of ENTRIES 32-byte keys, searched for each key in
// word; an exact match returns its lowest index as found, otherwise the key goes into the
// lowest row whose first 32-bit word is zero (inserted), or the result is full. The table
// reads empty after reset with no clearing pass: a fill count marks the written rows.
// After its key is accepted, the lookup passes through the scan, flush and resolve states:
// the scan reads one 256-bit row per step, the flush makes the last compare, and the resolve
// step loads the result word into its register. The next key is taken once the block is
// back in idle, so a new key is not accepted until the last key's result is loaded, while a
// result may still wait on the output. A result that is not taken holds the block in the resolve step.
// Depends on ktfi_pkg, ktfi_if, ktfi_dp and ktfi_ctrl.
module key_table_find_or_insert #(
    parameter int ENTRIES = ktfi_pkg::DEF_ENTRIES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ktfi_key_if.sink   i_key,
    ktfi_res_if.source o_res
);
    import ktfi_pkg::*;

    t_dp_cmd w_cmd;
    logic    w_scan_last;
    t_row    w_key;

    assign w_key = {i_key.key_word3, i_key.key_word2, i_key.key_word1, i_key.key_word0};

    ktfi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_key.valid),
        .o_in_ready  (i_key.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_scan_last (w_scan_last),
        .o_cmd       (w_cmd)
    );

    ktfi_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_key        (w_key),
        .o_scan_last  (w_scan_last),
        .o_slot_index (o_res.slot_index),
        .o_outcome    (o_res.outcome)
    );

`ifndef SYNTHESIS
    // One key in flight: no second key right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_key.valid && i_key.ready) |=> !i_key.ready)
        else $error("key accepted while a lookup is in flight");

    // A commit always presents a result word next cycle
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_res.valid)
        else $error("commit did not load the result word");

    // Commands never overlap
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.start, w_cmd.scan, w_cmd.commit}))
        else $error("overlapping datapath commands");

    // Presented outcome is a defined code
    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.outcome == OUTCOME_FOUND ||
                         o_res.outcome == OUTCOME_INSERTED ||
                         o_res.outcome == OUTCOME_FULL))
        else $error("undefined outcome code");
`endif

endmodule

[hw/rtl/ktfi_dp.sv]
// ktfi_dp: table memory, fill count, scan address, compare and result register.
// Depends on ktfi_pkg; driven by ktfi_ctrl through t_dp_cmd.
module ktfi_dp #(
    parameter int ENTRIES = ktfi_pkg::DEF_ENTRIES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ktfi_pkg::t_dp_cmd  i_cmd,
    input  ktfi_pkg::t_row     i_key,
    output logic               o_scan_last,
    output ktfi_pkg::t_slot    o_slot_index,
    output ktfi_pkg::t_outcome o_outcome
);
    import ktfi_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int FW = $clog2(ENTRIES + 1);

    t_row          r_mem [ENTRIES];
    t_row          r_key;
    logic [IW-1:0] r_addr;
    logic [IW-1:0] r_cmp_idx;
    logic          r_cmp_valid;
    t_row          r_rd_row;
    logic          r_rd_blank;
    logic [FW-1:0] r_fill;
    logic          r_found;
    logic [IW-1:0] r_found_idx;
    logic          r_has_empty;
    logic [IW-1:0] r_empty_idx;
    t_slot         r_slot;
    t_outcome      r_outcome;

    t_row          w_row;
    logic          w_match;
    logic          w_empty;
    logic          w_insert;

    // Rows at or past the fill count were never written and read as zero
    assign w_row    = r_rd_blank ? '0 : r_rd_row;
    assign w_match  = (w_row == r_key);
    assign w_empty  = (w_row[EMPTY_W-1:0] == '0);
    assign w_insert = i_cmd.commit && !r_found && r_has_empty;

    assign o_scan_last  = (r_addr == IW'(ENTRIES - 1));
    assign o_slot_index = r_slot;
    assign o_outcome    = r_outcome;

    // Capture the key word
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key <= i_key;
        end
    end

    // Advance the scan address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_cmp_valid <= 1'b0;
        end else begin
            r_cmp_valid <= i_cmd.scan;
            if (i_cmd.start) begin
                r_addr <= '0;
            end else if (i_cmd.scan) begin
                r_addr <= r_addr + 1'b1;
            end
        end
    end

    // Registered table read
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_rd_row   <= r_mem[r_addr];
            r_rd_blank <= (FW'(r_addr) >= r_fill);
            r_cmp_idx  <= r_addr;
        end
    end

    // Table write on insert
    always_ff @(posedge i_clk) begin
        if (w_insert) begin
            r_mem[r_empty_idx] <= r_key;
        end
    end

    // Grow the written prefix when the insert lands just past it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_insert && (FW'(r_empty_idx) == r_fill)) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    // Track the lowest match and the lowest empty row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found     <= 1'b0;
            r_has_empty <= 1'b0;
        end else if (i_cmd.start) begin
            r_found     <= 1'b0;
            r_has_empty <= 1'b0;
        end else if (r_cmp_valid) begin
            if (!r_found && w_match) begin
                r_found <= 1'b1;
            end
            if (!r_has_empty && w_empty) begin
                r_has_empty <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cmp_valid) begin
            if (!r_found && w_match) begin
                r_found_idx <= r_cmp_idx;
            end
            if (!r_has_empty && w_empty) begin
                r_empty_idx <= r_cmp_idx;
            end
        end
    end

    // Load the result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_found) begin
                r_slot    <= SLOT_W'(r_found_idx);
                r_outcome <= OUTCOME_FOUND;
            end else if (r_has_empty) begin
                r_slot    <= SLOT_W'(r_empty_idx);
                r_outcome <= OUTCOME_INSERTED;
            end else begin
                r_slot    <= '0;
                r_outcome <= OUTCOME_FULL;
            end
        end
    end

endmodule

[hw/rtl/ktfi_ctrl.sv]
// ktfi_ctrl: sequencer for one lookup: accept, scan, flush, resolve.
// Depends on ktfi_pkg; drives ktfi_dp through t_dp_cmd.
module ktfi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  logic              i_scan_last,
    output ktfi_pkg::t_dp_cmd o_cmd
);
    import ktfi_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_SCAN    = 4'b0010,
        ST_FLUSH   = 4'b0100,
        ST_RESOLVE = 4'b1000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    t_dp_cmd w_cmd;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.start = 1'b1;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                w_cmd.scan = 1'b1;
                if (i_scan_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                n_state = ST_RESOLVE;
            end
            ST_RESOLVE: begin
                // hold until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Result register occupancy
    always_comb begin
        if (w_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
